[rtl/core/aipd_pkg.sv]
// Shared constants, event codes and the result record of the IPD response parser.
package aipd_pkg;

  localparam int unsigned MAX_PAYLOAD = 2048;
  localparam int unsigned LINE_MAX    = 255;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned OFS_W   = 4;
  localparam int unsigned CNT_W   = $clog2(LINE_MAX + 1);
  localparam int unsigned SUF_W   = 56;
  // Room for accum * 10 + 9 before saturation.
  localparam int unsigned ACC_W   = LEN_W + 4;

  localparam logic [OFS_W-1:0]  DEFAULT_OFFSET = OFS_W'(6);

  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam logic [31:0]      OK_TEXT    = 32'h4F4B0D0A;
  localparam logic [SUF_W-1:0] ERROR_TEXT = 56'h4552524F520D0A;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] LINE_TOP = CNT_W'(LINE_MAX);

  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_OK     = 2'd1,
    EV_ERROR  = 2'd2,
    EV_HEADER = 2'd3
  } event_t;

  typedef struct packed {
    event_t              ev;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [LEN_W-1:0]    len;
  } res_t;

endpackage

[rtl/core/aipd_in_stage.sv]
// Input register that holds one received byte until the parser takes it.
module aipd_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aipd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          take,
  output logic                          held_valid,
  output logic [aipd_pkg::BYTE_W-1:0]   held_byte
);

  logic                        vld_r;
  logic [aipd_pkg::BYTE_W-1:0] byte_r;

  assign in_ready   = !vld_r || take;
  assign held_valid = vld_r;
  assign held_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

[rtl/core/aipd_parse.sv]
// Line, header and payload tracking; decides the result of one byte.
module aipd_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [aipd_pkg::OFS_W-1:0]    cfg_wr_data,
  input  logic                          step,
  input  logic [aipd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          res_valid,
  output aipd_pkg::res_t                res
);

  logic [aipd_pkg::OFS_W-1:0] offset_r;
  logic                       in_header_r,  in_header_nxt;
  logic                       in_payload_r, in_payload_nxt;
  logic [aipd_pkg::CNT_W-1:0] line_count_r, line_count_nxt;
  logic [aipd_pkg::SUF_W-1:0] suffix_r,     suffix_nxt;
  logic [aipd_pkg::LEN_W-1:0] accum_r,      accum_nxt;
  logic                       digits_done_r, digits_done_nxt;
  logic [aipd_pkg::LEN_W-1:0] remain_r,     remain_nxt;

  logic [aipd_pkg::SUF_W-1:0] shifted;
  logic [aipd_pkg::ACC_W-1:0] acc_wide;
  logic                       is_digit;
  logic                       is_last;

  assign shifted  = {suffix_r[aipd_pkg::SUF_W-9:0], rx_byte};
  assign is_digit = (rx_byte >= aipd_pkg::CH_ZERO) && (rx_byte <= aipd_pkg::CH_NINE);
  assign acc_wide = (aipd_pkg::ACC_W'(accum_r) << 3) + (aipd_pkg::ACC_W'(accum_r) << 1)
                  + aipd_pkg::ACC_W'(rx_byte[3:0]);
  assign is_last  = (remain_r <= aipd_pkg::LEN_W'(1));

  always_comb begin
    in_header_nxt   = in_header_r;
    in_payload_nxt  = in_payload_r;
    line_count_nxt  = line_count_r;
    suffix_nxt      = suffix_r;
    accum_nxt       = accum_r;
    digits_done_nxt = digits_done_r;
    remain_nxt      = remain_r;
    res_valid       = 1'b0;
    res             = '{ev: aipd_pkg::EV_DATA, data: '0, last: 1'b0, len: '0};

    if (in_payload_r) begin
      res_valid = 1'b1;
      res.data  = rx_byte;
      res.last  = is_last;
      if (is_last) begin
        remain_nxt     = '0;
        in_payload_nxt = 1'b0;
      end else begin
        remain_nxt = remain_r - aipd_pkg::LEN_W'(1);
      end
    end else if (line_count_r == '0 && rx_byte == aipd_pkg::CH_PLUS) begin
      in_header_nxt = 1'b1;
    end else if (in_header_r && rx_byte == aipd_pkg::CH_COLON) begin
      // The accumulator already saturates at the maximum length.
      res_valid       = 1'b1;
      res.ev          = aipd_pkg::EV_HEADER;
      res.len         = accum_r;
      in_header_nxt   = 1'b0;
      line_count_nxt  = '0;
      suffix_nxt      = '0;
      accum_nxt       = '0;
      digits_done_nxt = 1'b0;
      if (accum_r != '0) begin
        in_payload_nxt = 1'b1;
        remain_nxt     = accum_r;
      end
    end else begin
      suffix_nxt = shifted;
      if (line_count_r < aipd_pkg::LINE_TOP) begin
        if (aipd_pkg::CNT_W'(offset_r) <= line_count_r && !digits_done_r) begin
          if (is_digit) begin
            if (acc_wide > aipd_pkg::ACC_W'(aipd_pkg::MAX_LEN)) begin
              accum_nxt = aipd_pkg::MAX_LEN;
            end else begin
              accum_nxt = acc_wide[aipd_pkg::LEN_W-1:0];
            end
          end else begin
            digits_done_nxt = 1'b1;
          end
        end
        line_count_nxt = line_count_r + aipd_pkg::CNT_W'(1);
      end else begin
        digits_done_nxt = 1'b1;
      end

      if (rx_byte == aipd_pkg::CH_NL) begin
        line_count_nxt  = '0;
        suffix_nxt      = '0;
        accum_nxt       = '0;
        digits_done_nxt = 1'b0;
        in_header_nxt   = 1'b0;
        // ERROR wins when both texts match the end of the line.
        if (shifted == aipd_pkg::ERROR_TEXT) begin
          res_valid = 1'b1;
          res.ev    = aipd_pkg::EV_ERROR;
        end else if (shifted[31:0] == aipd_pkg::OK_TEXT) begin
          res_valid = 1'b1;
          res.ev    = aipd_pkg::EV_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r      <= aipd_pkg::DEFAULT_OFFSET;
      in_header_r   <= 1'b0;
      in_payload_r  <= 1'b0;
      line_count_r  <= '0;
      suffix_r      <= '0;
      accum_r       <= '0;
      digits_done_r <= 1'b0;
      remain_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (step) begin
        in_header_r   <= in_header_nxt;
        in_payload_r  <= in_payload_nxt;
        line_count_r  <= line_count_nxt;
        suffix_r      <= suffix_nxt;
        accum_r       <= accum_nxt;
        digits_done_r <= digits_done_nxt;
        remain_r      <= remain_nxt;
      end
    end
  end

endmodule

[rtl/core/aipd_out_stage.sv]
// Result register that holds one result until the consumer takes it.
module aipd_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          res_valid,
  input  aipd_pkg::res_t                res,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_res,
  output logic [aipd_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                          out_is_last,
  output logic [aipd_pkg::LEN_W-1:0]    out_payload_length
);

  logic           vld_r;
  aipd_pkg::res_t res_r;

  assign busy               = vld_r && !out_ready;
  assign out_valid          = vld_r;
  assign out_event_res      = res_r.ev;
  assign out_data_byte      = res_r.data;
  assign out_is_last        = res_r.last;
  assign out_payload_length = res_r.len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= res_valid;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

[rtl/core/at_response_ipd_parser.sv]
// Top level of the modem response parser for IPD data headers.
//
//   channel  direction  request fields
//   in_      input      rx_byte (8)
//   out_     output     event_res (2), data_byte (8), is_last (1), payload_length (12)
//   cfg_     input      length_offset (4), write only, no handshake
//
// One byte per cycle is sustained while out_ready is high; an accepted byte
// is parsed from the input register once the result register can take its result.
// The single parse step between the input and result registers sets the rate.
// Reset is synchronous and active low and clears all parser state; the offset
// returns to 6. A stalled result holds the parser and then the input register.
module at_response_ipd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aipd_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_res,
  output logic [aipd_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                          out_is_last,
  output logic [aipd_pkg::LEN_W-1:0]    out_payload_length,
  input  logic                          cfg_wr_en,
  input  logic [aipd_pkg::OFS_W-1:0]    cfg_wr_data
);

  logic                        held_valid;
  logic [aipd_pkg::BYTE_W-1:0] held_byte;
  logic                        step;
  logic                        out_busy;
  logic                        res_valid;
  aipd_pkg::res_t              res;

  assign step = held_valid && !out_busy;

  aipd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  aipd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (held_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  aipd_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (step),
    .res_valid          (res_valid),
    .res                (res),
    .busy               (out_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_data_byte      (out_data_byte),
    .out_is_last        (out_is_last),
    .out_payload_length (out_payload_length)
  );

endmodule

[verif/at_response_ipd_parser_test.sv]
// Self-checking testbench for the IPD response parser: directed table, then random phases.
`timescale 1ns / 100ps

module at_response_ipd_parser_test;
  import aipd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 90;
  localparam int N_DIR        = 25;
  localparam int MAX_REPORTS  = 10;

  localparam res_t NO_RES = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              typed;
    res_t              res;
  } dir_row_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte  = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [1:0]        out_event_res;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_is_last;
  logic [LEN_W-1:0]  out_payload_length;
  logic              cfg_wr_en   = 1'b0;
  logic [OFS_W-1:0]  cfg_wr_data = '0;

  // Parser state as this bench tracks it.
  logic [OFS_W-1:0]  length_ofs     = DEFAULT_OFFSET;
  logic              hdr_mode       = 1'b0;
  logic              payload_mode   = 1'b0;
  logic [CNT_W-1:0]  line_len       = '0;
  logic [SUF_W-1:0]  line_tail      = '0;
  logic [LEN_W-1:0]  len_accum      = '0;
  logic              digit_run_over = 1'b0;
  logic [LEN_W-1:0]  payload_left   = '0;

  res_t expected_events[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int n_sent         = 0;
  int n_cfg          = 0;
  int n_errors       = 0;
  int n_data         = 0;
  int n_hdr          = 0;
  int n_status       = 0;
  int cycle_count    = 0;

  // Directed requests at the reset offset of 6: short header, a three-byte
  // packet with extreme payload values, then an OK line and an ERROR line.
  dir_row_t dir_table [N_DIR] = '{
    '{8'h2B, 1'b0, NO_RES},
    '{8'h3A, 1'b1, '{EV_HEADER, 8'h00, 1'b0, 12'd0}},
    '{8'h2B, 1'b0, NO_RES},
    '{8'h49, 1'b0, NO_RES},
    '{8'h50, 1'b0, NO_RES},
    '{8'h44, 1'b0, NO_RES},
    '{8'h2C, 1'b0, NO_RES},
    '{8'h30, 1'b0, NO_RES},
    '{8'h2C, 1'b0, NO_RES},
    '{8'h33, 1'b0, NO_RES},
    '{8'h3A, 1'b1, '{EV_HEADER, 8'h00, 1'b0, 12'd3}},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h61, 1'b1, '{EV_DATA, 8'h61, 1'b1, 12'd0}},
    '{8'h4F, 1'b0, NO_RES},
    '{8'h4B, 1'b0, NO_RES},
    '{8'h0D, 1'b0, NO_RES},
    '{8'h0A, 1'b1, '{EV_OK, 8'h00, 1'b0, 12'd0}},
    '{8'h45, 1'b0, NO_RES},
    '{8'h52, 1'b0, NO_RES},
    '{8'h52, 1'b0, NO_RES},
    '{8'h4F, 1'b0, NO_RES},
    '{8'h52, 1'b0, NO_RES},
    '{8'h0D, 1'b0, NO_RES},
    '{8'h0A, 1'b1, '{EV_ERROR, 8'h00, 1'b0, 12'd0}}
  };

  at_response_ipd_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_is_last       (out_is_last),
    .out_payload_length(out_payload_length),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding.", cycle_count,
               expected_events.size());
      $display("** at_response_ipd_parser: FAILED **");
      $finish;
    end
  end

  function automatic void clear_line_state();
    line_len       = '0;
    line_tail      = '0;
    len_accum      = '0;
    digit_run_over = 1'b0;
  endfunction

  // Advances the tracked parser state by one byte; returns 1 with the result
  // when the byte produces one.
  function automatic bit parse_step(input logic [BYTE_W-1:0] b, output res_t r);
    int  acc;
    bit  is_err;
    bit  is_ok;
    r = '0;
    if (payload_mode) begin
      r.ev   = EV_DATA;
      r.data = b;
      r.last = (payload_left <= 1);
      if (r.last) begin
        payload_left = '0;
        payload_mode = 1'b0;
      end else begin
        payload_left = payload_left - 1'b1;
      end
      return 1'b1;
    end
    if (line_len == 0 && b == CH_PLUS) begin
      hdr_mode = 1'b1;
      return 1'b0;
    end
    if (hdr_mode && b == CH_COLON) begin
      r.ev = EV_HEADER;
      r.len = (len_accum > MAX_LEN) ? MAX_LEN : len_accum;
      hdr_mode = 1'b0;
      clear_line_state();
      if (r.len != 0) begin
        payload_mode = 1'b1;
        payload_left = r.len;
      end
      return 1'b1;
    end
    line_tail = {line_tail[SUF_W-9:0], b};
    if (line_len < LINE_MAX) begin
      if (line_len >= length_ofs && !digit_run_over) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          acc = int'(len_accum) * 10 + int'(b - CH_ZERO);
          if (acc > MAX_PAYLOAD) acc = MAX_PAYLOAD;
          len_accum = LEN_W'(acc);
        end else begin
          digit_run_over = 1'b1;
        end
      end
      line_len = line_len + 1'b1;
    end else begin
      digit_run_over = 1'b1;
    end
    if (b == CH_NL) begin
      is_err = (line_tail == ERROR_TEXT);
      is_ok  = (line_tail[31:0] == OK_TEXT);
      clear_line_state();
      hdr_mode = 1'b0;
      if (is_err) begin
        r.ev = EV_ERROR;
        return 1'b1;
      end
      if (is_ok) begin
        r.ev = EV_OK;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Offers one request, with random idle cycles in front of it, and records
  // the expected result once it is accepted.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit use_typed = 1'b0,
                           input res_t typed_res = '0);
    res_t r;
    bit   has_res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    has_res = parse_step(b, r);
    if (use_typed) expected_events.push_back(typed_res);
    else if (has_res) expected_events.push_back(r);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [BYTE_W-1:0] header_fill_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (b == CH_COLON || b == CH_NL);
    return b;
  endfunction

  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 0;
    if (p < 80) return $urandom_range(1, 16);
    if (p < 95) return $urandom_range(17, 80);
    return $urandom_range(81, 400);
  endfunction

  // form 0: well formed, 1: space before the digits, 2: colon before the
  // offset, 3: extra field after the digits. Payload follows as tracked.
  task automatic send_ipd(input int len, input int form);
    string digits;
    int    i;
    int    n_fill;
    digits = $sformatf("%0d", len);
    send_byte(CH_PLUS);
    if (form == 2) begin
      n_fill = (length_ofs == 0) ? 0 : $urandom_range(length_ofs - 1);
      for (i = 0; i < n_fill; i++) send_byte(header_fill_byte());
    end else begin
      for (i = 0; i < length_ofs; i++) send_byte(header_fill_byte());
      if (form == 1) send_byte(8'h20);
      send_text(digits);
      if (form == 3) send_text(",x");
    end
    send_byte(CH_COLON);
    while (payload_mode) send_byte(BYTE_W'($urandom_range(255)));
  endtask

  task automatic send_status_line(input int kind);
    int i;
    int n_pre;
    n_pre = $urandom_range(6);
    for (i = 0; i < n_pre; i++) send_byte(8'h41 + BYTE_W'($urandom_range(25)));
    case (kind)
      0: send_text("OK\r\n");
      1: send_text("ERROR\r\n");
      2: send_text("OK\n");
      default: send_text("\r\n");
    endcase
  endtask

  // A line longer than the line counter can hold, either a header that ends
  // in a colon or a plain line that ends in OK.
  task automatic send_long_line(input bit as_header);
    int i;
    send_byte(as_header ? CH_PLUS : 8'h4C);
    for (i = 0; i < 262; i++) send_byte(8'h61 + BYTE_W'($urandom_range(25)));
    if (as_header) send_byte(CH_COLON);
    else send_text("OK\r\n");
  endtask

  task automatic send_random_sequence();
    int pick;
    int i;
    int n;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_ipd(pick_len(), ($urandom_range(3) == 0) ? 3 : 0);
    end else if (pick < 53) begin
      send_ipd(pick_len(), $urandom_range(1, 2));
    end else if (pick < 76) begin
      send_status_line($urandom_range(3));
    end else if (pick < 98) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) send_byte(BYTE_W'($urandom_range(255)));
    end else begin
      send_long_line(1'($urandom_range(1)));
    end
  endtask

  // Waits until every expected result is back, then lets the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [OFS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    length_ofs  = v;
    n_cfg++;
  endtask

  task automatic report_error(input string what, input res_t want);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%s at cycle %0d: expected ev=%0d data=%02h last=%0b len=%0d,", what,
               cycle_count, want.ev, want.data, want.last, want.len);
      $display("  got ev=%0d data=%02h last=%0b len=%0d", out_event_res, out_data_byte,
               out_is_last, out_payload_length);
    end
  endtask

  task automatic check_result();
    res_t want;
    if (expected_events.size() == 0) begin
      report_error("Unexpected result", NO_RES);
    end else begin
      want = expected_events.pop_front();
      if (out_event_res !== want.ev || out_data_byte !== want.data ||
          out_is_last !== want.last || out_payload_length !== want.len) begin
        report_error("Mismatch", want);
      end
      case (want.ev)
        EV_DATA:   n_data++;
        EV_HEADER: n_hdr++;
        default:   n_status++;
      endcase
    end
  endtask

  // Result side: checks every accepted result and drives ready, with random
  // stalls and one long hold-off.
  always @(posedge clk) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (out_valid && out_ready) check_result();
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int i;
    int ph;
    int start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      send_byte(dir_table[i].b, dir_table[i].typed, dir_table[i].res);
    end
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_offset('0);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_offset('1);
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          write_offset(OFS_W'($urandom_range(1, 14)));
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          write_offset(OFS_W'($urandom_range(15)));
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      if (ph == 0) begin
        // The result side holds off while a packet keeps arriving, so the
        // input backs up.
        hold_request++;
        send_ipd(60, 0);
      end
      if (ph == 1) send_long_line(1'b0);
      start = n_sent;
      while (n_sent < start + PHASE_ITEMS) send_random_sequence();
      drain();
    end

    if (expected_events.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived.", expected_events.size());
    end
    $display("Sent %0d requests under %0d offset settings and four idle patterns.",
             n_sent, n_cfg + 1);
    $display("Checked %0d headers, %0d payload bytes and %0d status lines; %0d errors.",
             n_hdr, n_data, n_status, n_errors);
    if (n_errors == 0) begin
      $display("** at_response_ipd_parser: PASSED **");
    end else begin
      $display("** at_response_ipd_parser: FAILED **");
    end
    $finish;
  end

endmodule
